// File: rtl/wsd_pkg.sv
// shared types and constants of the work stealing task dispatcher
// no dependencies; imported by the interfaces, the top level and the checker
package wsd_pkg;

  localparam int NUM_WORKERS_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 16;
  localparam int ENTRY_W         = ID_W + 1;
  localparam int CFG_AW          = 3;

  localparam logic [2:0] WC_RESET = 3'd4;

  // operation codes of an input word
  localparam logic OP_SCHED = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_CALLER_MODE  = 1'b0;
  localparam logic REG_WORKER_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_ENQ    = 3'd0,
    ST_FULL   = 3'd1,
    ST_OWN    = 3'd2,
    ST_STOLEN = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

endpackage

// File: rtl/wsd_if.sv
// valid/ready channel interfaces for input and result words
// depends on wsd_pkg
interface wsd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [wsd_pkg::ID_W-1:0]  new_task_id;
  logic                      pinned;
  logic [1:0]                pinned_worker;
  logic                      is_worker;
  logic [1:0]                worker_sel;
  logic                      caller_running;

  modport source (output valid, op, new_task_id, pinned, pinned_worker, is_worker,
                  worker_sel, caller_running, input ready);
  modport sink   (input valid, op, new_task_id, pinned, pinned_worker, is_worker,
                  worker_sel, caller_running, output ready);
endinterface

interface wsd_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [wsd_pkg::ID_W-1:0]  got_task_id;
  logic                      task_pinned;
  logic [1:0]                queue_worker;

  modport source (output valid, status, got_task_id, task_pinned, queue_worker,
                  input ready);
  modport sink   (input valid, status, got_task_id, task_pinned, queue_worker,
                  output ready);
endinterface

// File: rtl/wsd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module wsd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/work_stealing_task_dispatcher_unit.sv
// Work stealing task dispatcher. One word in on in_ch, one result word out on
// out_ch, both valid/ready. Registers caller mode (addr 0) and worker_count
// (addr 4) on the APB port; pready is always high, write them while idle.
// A schedule word picks a worker (pin, own, else round robin) and pushes the
// task to that worker's local or remote ring. A fetch word drains the remote
// ring into the local one, pops the local front, or else steals the newest
// unpinned entry from another worker, scanning in index order.
// All queue storage sits in two rams driven by one small sequencer, one ram
// access a step; in_ch.ready is high only while the sequencer is idle.
// Each word is dispatched, then enqueued, or drained and popped, or stolen by a
// victim scan and a shift that closes the gap behind the stolen entry; a fetch
// by an out-of-range worker goes straight to the result.
// The result sits in an output register; the next word is taken while it
// waits, and a finished result waits in the last step until out_ch is free.
// Reset (synchronous, rst_n low) empties every queue, clears the round robin
// cursor and restores caller mode 0, worker_count 4; the rams need no clearing.
// depends on wsd_pkg, wsd_if, wsd_ram
module work_stealing_task_dispatcher_unit #(
  parameter int NUM_WORKERS = wsd_pkg::NUM_WORKERS_DEF,
  parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wsd_in_if.sink                     in_ch,
  wsd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wsd_pkg::*;

  localparam int WW  = $clog2(NUM_WORKERS);
  localparam int CW  = $clog2(NUM_WORKERS + 1);
  localparam int XW  = CW + 2;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = FW + 1;
  localparam int RD  = NUM_WORKERS * QUEUE_DEPTH;
  localparam int AW  = $clog2(RD);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_DISP    = 12'b000000000010,
    S_ENQ     = 12'b000000000100,
    S_DRAIN   = 12'b000000001000,
    S_DR_WR   = 12'b000000010000,
    S_POP     = 12'b000000100000,
    S_SC_VIC  = 12'b000001000000,
    S_SC_RD   = 12'b000010000000,
    S_SC_EVAL = 12'b000100000000,
    S_SH_RD   = 12'b001000000000,
    S_SH_WR   = 12'b010000000000,
    S_DONE    = 12'b100000000000
  } state_t;

  function automatic logic [AW-1:0] addr_of(logic [WW-1:0] w, logic [PW-1:0] s);
    return AW'(int'(w) * QUEUE_DEPTH + int'(s));
  endfunction

  // slot k behind head, wrapped once
  function automatic logic [PW-1:0] ring(logic [PW-1:0] h, logic [FW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(k);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] inc_ptr(logic [PW-1:0] h);
    return (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  state_t             state_r;
  logic               caller_mode_r;
  logic [2:0]         wcount_r;
  logic               op_r, pin_r, isw_r, crun_r;
  logic [ID_W-1:0]    id_r;
  logic [1:0]         pw_r, wi_r;
  logic [CW-1:0]      cw_r;
  logic               to_local_r;
  logic [FW-1:0]      k_r;
  logic [PW-1:0]      lhead_r [NUM_WORKERS];
  logic [FW-1:0]      lfill_r [NUM_WORKERS];
  logic [PW-1:0]      rhead_r [NUM_WORKERS];
  logic [FW-1:0]      rfill_r [NUM_WORKERS];
  logic [31:0]        cursor_r;
  logic [WW-1:0]      rem_r [NUM_WORKERS];
  status_t            res_status_r;
  logic [ID_W-1:0]    res_id_r;
  logic               res_pin_r;
  logic [1:0]         res_qw_r;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_pin_r;
  logic [1:0]         out_qw_r;

  logic [CW-1:0]      n_eff;
  logic [XW-1:0]      n_x;
  logic [WW-1:0]      cur;
  logic [PW-1:0]      cur_lhead, cur_rhead;
  logic [FW-1:0]      cur_lfill, cur_rfill;
  logic               wi_ok, pin_ok, own, use_rr;
  logic [WW-1:0]      rem_n, rem_n1, rr_w, pick_w;

  logic               l_we, r_we;
  logic [AW-1:0]      l_waddr, r_waddr, l_raddr, r_raddr;
  logic [ENTRY_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

  // effective worker count
  always_comb begin
    if (wcount_r == 3'd0) begin
      n_eff = CW'(1);
    end else if (int'(wcount_r) > NUM_WORKERS) begin
      n_eff = CW'(NUM_WORKERS);
    end else begin
      n_eff = CW'(wcount_r);
    end
  end
  assign n_x = XW'(n_eff);

  assign cur       = cw_r[WW-1:0];
  assign cur_lhead = lhead_r[cur];
  assign cur_rhead = rhead_r[cur];
  assign cur_lfill = lfill_r[cur];
  assign cur_rfill = rfill_r[cur];

  // cursor residues for moduli n and n-1
  always_comb begin
    rem_n  = '0;
    rem_n1 = '0;
    for (int i = 0; i < NUM_WORKERS; i++) begin
      if (CW'(i + 1) == n_eff) rem_n = rem_r[i];
      if (CW'(i + 2) == n_eff) rem_n1 = rem_r[i];
    end
  end

  // worker selection for a schedule word
  always_comb begin
    wi_ok  = XW'(wi_r) < n_x;
    pin_ok = pin_r && (XW'(pw_r) < n_x);
    own    = isw_r && wi_ok;
    use_rr = !pin_ok && !own;
    if (caller_mode_r && (n_eff > CW'(1)) && !crun_r) begin
      rr_w = rem_n1 + 1'b1;
    end else begin
      rr_w = rem_n;
    end
    if (pin_ok) begin
      pick_w = WW'(pw_r);
    end else if (own) begin
      pick_w = WW'(wi_r);
    end else begin
      pick_w = rr_w;
    end
  end

  // ram ports
  assign l_raddr = addr_of(cur, ring(cur_lhead, k_r));
  assign r_raddr = addr_of(cur, cur_rhead);
  assign r_waddr = addr_of(cur, ring(cur_rhead, cur_rfill));
  assign r_wdata = {pin_r, id_r};

  always_comb begin
    l_we    = 1'b0;
    r_we    = 1'b0;
    l_waddr = addr_of(cur, ring(cur_lhead, cur_lfill));
    l_wdata = {pin_r, id_r};
    case (state_r)
      S_ENQ: begin
        if (to_local_r) begin
          l_we = cur_lfill < FW'(QUEUE_DEPTH);
        end else begin
          r_we = cur_rfill < FW'(QUEUE_DEPTH);
        end
      end
      S_DR_WR: begin
        l_we    = 1'b1;
        l_wdata = r_rdata;
      end
      S_SH_WR: begin
        l_we    = 1'b1;
        l_waddr = addr_of(cur, ring(cur_lhead, k_r - 1'b1));
        l_wdata = l_rdata;
      end
      default: begin
        l_we = 1'b0;
      end
    endcase
  end

  wsd_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_local_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  wsd_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_remote_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // sequencer, queue pointers and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      caller_mode_r <= 1'b0;
      wcount_r      <= WC_RESET;
      cursor_r      <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        lhead_r[i] <= '0;
        lfill_r[i] <= '0;
        rhead_r[i] <= '0;
        rfill_r[i] <= '0;
        rem_r[i]   <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_CALLER_MODE:  caller_mode_r <= pwdata[0];
          REG_WORKER_COUNT: wcount_r      <= pwdata[2:0];
          default:          caller_mode_r <= caller_mode_r;
        endcase
      end

      // a taken word leaves the output register unless a new one replaces it
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.op;
            id_r    <= in_ch.new_task_id;
            pin_r   <= in_ch.pinned;
            pw_r    <= in_ch.pinned_worker;
            isw_r   <= in_ch.is_worker;
            wi_r    <= in_ch.worker_sel;
            crun_r  <= in_ch.caller_running;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          k_r       <= '0;
          res_id_r  <= '0;
          res_pin_r <= 1'b0;
          if (op_r == OP_SCHED) begin
            cw_r       <= CW'(pick_w);
            to_local_r <= own && (pick_w == WW'(wi_r));
            res_qw_r   <= 2'(pick_w);
            state_r    <= S_ENQ;
            // advance the shared cursor and its residues
            if (use_rr) begin
              cursor_r <= cursor_r + 1'b1;
              for (int i = 0; i < NUM_WORKERS; i++) begin
                if (cursor_r == '1 || rem_r[i] == WW'(i)) begin
                  rem_r[i] <= '0;
                end else begin
                  rem_r[i] <= rem_r[i] + 1'b1;
                end
              end
            end
          end else if (!wi_ok) begin
            res_qw_r     <= '0;
            res_status_r <= ST_NONE;
            state_r      <= S_DONE;
          end else begin
            res_qw_r     <= '0;
            res_status_r <= ST_NONE;
            cw_r         <= CW'(wi_r);
            state_r      <= S_DRAIN;
          end
        end
        S_ENQ: begin
          if (to_local_r) begin
            if (cur_lfill < FW'(QUEUE_DEPTH)) begin
              lfill_r[cur] <= cur_lfill + 1'b1;
              res_status_r <= ST_ENQ;
            end else begin
              res_status_r <= ST_FULL;
            end
          end else begin
            if (cur_rfill < FW'(QUEUE_DEPTH)) begin
              rfill_r[cur] <= cur_rfill + 1'b1;
              res_status_r <= ST_ENQ;
            end else begin
              res_status_r <= ST_FULL;
            end
          end
          state_r <= S_DONE;
        end
        S_DRAIN: begin
          if (cur_rfill != '0 && cur_lfill < FW'(QUEUE_DEPTH)) begin
            state_r <= S_DR_WR;
          end else if (cur_lfill != '0) begin
            state_r <= S_POP;
          end else begin
            cw_r    <= '0;
            state_r <= S_SC_VIC;
          end
        end
        S_DR_WR: begin
          lfill_r[cur] <= cur_lfill + 1'b1;
          rfill_r[cur] <= cur_rfill - 1'b1;
          rhead_r[cur] <= inc_ptr(cur_rhead);
          state_r      <= S_DRAIN;
        end
        S_POP: begin
          res_status_r <= ST_OWN;
          res_id_r     <= l_rdata[ID_W-1:0];
          res_pin_r    <= l_rdata[ID_W];
          res_qw_r     <= 2'(cur);
          lhead_r[cur] <= inc_ptr(cur_lhead);
          lfill_r[cur] <= cur_lfill - 1'b1;
          state_r      <= S_DONE;
        end
        // pick the next victim queue
        S_SC_VIC: begin
          if (XW'(cw_r) >= n_x) begin
            state_r <= S_DONE;
          end else if (XW'(cw_r) == XW'(wi_r) || cur_lfill == '0) begin
            cw_r <= cw_r + 1'b1;
          end else begin
            k_r     <= cur_lfill - 1'b1;
            state_r <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          state_r <= S_SC_EVAL;
        end
        S_SC_EVAL: begin
          if (l_rdata[ID_W]) begin
            if (k_r == '0) begin
              cw_r    <= cw_r + 1'b1;
              state_r <= S_SC_VIC;
            end else begin
              k_r     <= k_r - 1'b1;
              state_r <= S_SC_RD;
            end
          end else begin
            res_status_r <= ST_STOLEN;
            res_id_r     <= l_rdata[ID_W-1:0];
            res_qw_r     <= 2'(cur);
            k_r          <= k_r + 1'b1;
            state_r      <= S_SH_RD;
          end
        end
        // close the gap behind the stolen entry
        S_SH_RD: begin
          if (k_r < cur_lfill) begin
            state_r <= S_SH_WR;
          end else begin
            lfill_r[cur] <= cur_lfill - 1'b1;
            state_r      <= S_DONE;
          end
        end
        S_SH_WR: begin
          k_r     <= k_r + 1'b1;
          state_r <= S_SH_RD;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_id_r     <= res_id_r;
            out_pin_r    <= res_pin_r;
            out_qw_r     <= res_qw_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_CALLER_MODE:  prdata = {31'd0, caller_mode_r};
      REG_WORKER_COUNT: prdata = {29'd0, wcount_r};
      default:          prdata = '0;
    endcase
  end

  assign pready              = 1'b1;
  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.got_task_id  = out_id_r;
  assign out_ch.task_pinned  = out_pin_r;
  assign out_ch.queue_worker = out_qw_r;

endmodule

// File: rtl/wsd_checker.sv
// port level checks on the result channel of the dispatcher, bound to the top
// depends on wsd_pkg and work_stealing_task_dispatcher_unit
module wsd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [2:0]               out_status,
  input logic [wsd_pkg::ID_W-1:0] out_id,
  input logic                     out_pin,
  input logic [1:0]               out_qw
);
  import wsd_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id)
      && $stable(out_pin) && $stable(out_qw))
    else $error("result word changed while stalled");

  // schedule results carry no task
  a_sched_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ENQ || out_status == ST_FULL) |->
      out_id == '0 && !out_pin)
    else $error("schedule result carries a task");

  // nothing found means an all-zero word
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |-> out_id == '0 && !out_pin && out_qw == '0)
    else $error("empty fetch result not zero");

  // a pinned task is never stolen
  a_steal_unpinned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_STOLEN |-> !out_pin)
    else $error("pinned task stolen");

endmodule

bind work_stealing_task_dispatcher_unit wsd_checker u_wsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_id     (out_ch.got_task_id),
  .out_pin    (out_ch.task_pinned),
  .out_qw     (out_ch.queue_worker)
);

// File: test/tb_wsd_pkg.sv
// testbench-side helpers for the work stealing dispatcher checker
// depends on wsd_pkg for widths and status codes
package tb_wsd_pkg;
  import wsd_pkg::*;

  // one input word as the checker sees it
  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  new_task_id;
    logic             pinned;
    logic [1:0]       pinned_worker;
    logic             is_worker;
    logic [1:0]       worker_sel;
    logic             caller_running;
  } sched_word_t;

  // one result word
  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  got_task_id;
    logic             task_pinned;
    logic [1:0]       queue_worker;
  } disp_result_t;

  localparam int NW = NUM_WORKERS_DEF;
  localparam int QD = QUEUE_DEPTH_DEF;
endpackage

// File: test/tb_top.sv
// self-checking bench for work_stealing_task_dispatcher_unit: directed table,
// then random schedule/fetch traffic under several idling phases
// depends on wsd_pkg, tb_wsd_pkg, wsd_if and the dispatcher rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;
  import tb_wsd_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wsd_in_if  in_ch();
  wsd_out_if out_ch();

  always #2 clk = ~clk;

  work_stealing_task_dispatcher_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the dispatcher state
  logic [ENTRY_W-1:0] loc_q [NW][QD];
  int unsigned loc_n [NW];
  logic [ENTRY_W-1:0] rem_q [NW][QD];
  int unsigned rem_hd [NW];
  int unsigned rem_n [NW];
  logic [31:0] rr_pos;
  logic sh_caller_mode;
  logic [2:0] sh_worker_count;

  disp_result_t pending_results[$];
  int n_errors = 0;
  int n_results = 0;
  int n_steals = 0;
  int n_full = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic void reset_shadow();
    for (int w = 0; w < NW; w++) begin
      loc_n[w] = 0; rem_hd[w] = 0; rem_n[w] = 0;
    end
    rr_pos = '0;
    sh_caller_mode = 1'b0;
    sh_worker_count = WC_RESET;
  endfunction

  // work out the result of one word and update the shadow
  function automatic disp_result_t dispatch_word(input sched_word_t s);
    disp_result_t r;
    int unsigned n, w, c;
    logic own;
    logic [ENTRY_W-1:0] ent;
    r = '0;
    n = (sh_worker_count == 0) ? 1 : (sh_worker_count > NW ? NW : sh_worker_count);
    if (s.op == OP_SCHED) begin
      own = s.is_worker && s.worker_sel < n;
      if (s.pinned && s.pinned_worker < n) w = s.pinned_worker;
      else if (own) w = s.worker_sel;
      else begin
        c = rr_pos;
        rr_pos = rr_pos + 1;
        if (sh_caller_mode && n > 1 && !s.caller_running) w = 1 + (c % (n - 1));
        else w = c % n;
      end
      ent = {s.pinned, s.new_task_id};
      r.queue_worker = w[1:0];
      r.status = ST_ENQ;
      if (own && s.worker_sel == w) begin
        if (loc_n[w] >= QD) r.status = ST_FULL;
        else begin loc_q[w][loc_n[w]] = ent; loc_n[w]++; end
      end else begin
        if (rem_n[w] >= QD) r.status = ST_FULL;
        else begin
          rem_q[w][(rem_hd[w] + rem_n[w]) % QD] = ent;
          rem_n[w]++;
        end
      end
      return r;
    end
    r.status = ST_NONE;
    w = s.worker_sel;
    if (w >= n) return r;
    // drain remote ring into local
    while (rem_n[w] > 0 && loc_n[w] < QD) begin
      loc_q[w][loc_n[w]] = rem_q[w][rem_hd[w]];
      loc_n[w]++;
      rem_hd[w] = (rem_hd[w] + 1) % QD;
      rem_n[w]--;
    end
    if (loc_n[w] > 0) begin
      ent = loc_q[w][0];
      for (int k = 1; k < loc_n[w]; k++) loc_q[w][k-1] = loc_q[w][k];
      loc_n[w]--;
      r.status = ST_OWN; r.got_task_id = ent[ID_W-1:0];
      r.task_pinned = ent[ID_W]; r.queue_worker = w[1:0];
      return r;
    end
    // steal newest unpinned entry, victims in index order
    for (int v = 0; v < n; v++) begin
      if (v == w) continue;
      for (int k = loc_n[v]; k > 0; k--) begin
        ent = loc_q[v][k-1];
        if (ent[ID_W]) continue;
        for (int m = k; m < loc_n[v]; m++) loc_q[v][m-1] = loc_q[v][m];
        loc_n[v]--;
        r.status = ST_STOLEN; r.got_task_id = ent[ID_W-1:0];
        r.queue_worker = v[1:0];
        return r;
      end
    end
    return r;
  endfunction

  // register write: setup then access
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_CALLER_MODE) sh_caller_mode = val[0];
    else sh_worker_count = val[2:0];
  endtask

  // send one word; prediction made at acceptance
  task automatic send_word(input sched_word_t s);
    @(negedge clk);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.op, in_ch.new_task_id, in_ch.pinned, in_ch.pinned_worker, in_ch.is_worker,
     in_ch.worker_sel, in_ch.caller_running} <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), dispatch_word(s));
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // wait until all results are back, then let the sequencer settle
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // result sink with random stalls and a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else
      out_ch.ready <= !(snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    disp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (want.status == ST_STOLEN) n_steals++;
        if (want.status == ST_FULL) n_full++;
        if (out_ch.status !== want.status)
          report_mismatch("status", int'(out_ch.status), int'(want.status));
        if (out_ch.got_task_id !== want.got_task_id)
          report_mismatch("got_task_id", int'(out_ch.got_task_id),
                          int'(want.got_task_id));
        if (out_ch.task_pinned !== want.task_pinned)
          report_mismatch("task_pinned", int'(out_ch.task_pinned),
                          int'(want.task_pinned));
        if (out_ch.queue_worker !== want.queue_worker)
          report_mismatch("queue_worker", int'(out_ch.queue_worker),
                          int'(want.queue_worker));
      end
    end
  end

  function automatic sched_word_t rand_word(input int fetch_pct);
    sched_word_t s;
    s = sched_word_t'($bits(sched_word_t)'($urandom));
    s.op = ($urandom_range(99) < fetch_pct) ? OP_FETCH : OP_SCHED;
    s.new_task_id = ID_W'($urandom);
    s.pinned = ($urandom_range(3) == 0);
    s.is_worker = ($urandom_range(2) != 0);
    return s;
  endfunction

  // directed rows: word plus typed expectation where it is obvious
  typedef struct {
    sched_word_t  s;
    logic         typed;
    disp_result_t r;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic sched_word_t mk(input logic op, input int id, input logic pin,
                                     input int pw, input logic isw, input int wi,
                                     input logic cr);
    sched_word_t s;
    s.op = op; s.new_task_id = ID_W'(id); s.pinned = pin; s.pinned_worker = 2'(pw);
    s.is_worker = isw; s.worker_sel = 2'(wi); s.caller_running = cr;
    return s;
  endfunction

  function automatic dir_row_t row(input sched_word_t s, input logic typed,
                                   input disp_result_t r);
    dir_row_t d;
    d.s = s; d.typed = typed; d.r = r;
    return d;
  endfunction

  function automatic void add_row(input dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  initial begin
    disp_result_t got;
    int items;
    in_ch.valid = 1'b0;
    {in_ch.op, in_ch.new_task_id, in_ch.pinned, in_ch.pinned_worker, in_ch.is_worker,
     in_ch.worker_sel, in_ch.caller_running} = '0;
    out_ch.ready = 1'b1;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    add_row(row(mk(OP_FETCH, 0, 0, 0, 0, 0, 0), 1, '{ST_NONE, 0, 0, 0}));
    add_row(row(mk(OP_SCHED, 16'hFFFF, 0, 0, 1, 3, 0), 1, '{ST_ENQ, 0, 0, 3}));
    add_row(row(mk(OP_SCHED, 0, 1, 2, 0, 0, 1), 1, '{ST_ENQ, 0, 0, 2}));
    add_row(row(mk(OP_SCHED, 16'h1234, 0, 0, 0, 0, 0), 0, '0));
    add_row(row(mk(OP_SCHED, 16'h5555, 1, 1, 1, 0, 1), 0, '0));
    add_row(row(mk(OP_FETCH, 16'hAAAA, 1, 3, 1, 3, 1), 1, '{ST_OWN, 16'hFFFF, 0, 3}));
    add_row(row(mk(OP_FETCH, 0, 0, 0, 0, 2, 0), 1, '{ST_OWN, 0, 1, 2}));
    add_row(row(mk(OP_FETCH, 0, 0, 0, 0, 1, 0), 0, '0));
    add_row(row(mk(OP_FETCH, 0, 0, 0, 0, 2, 0), 0, '0));
    add_row(row(mk(OP_SCHED, 16'h0042, 0, 0, 1, 1, 0), 0, '0));
    add_row(row(mk(OP_FETCH, 0, 0, 0, 0, 0, 0), 0, '0));
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].s);
      if (dir_rows[i].typed) begin
        got = pending_results[$];
        if (got !== dir_rows[i].r) report_mismatch("directed row", i, i);
      end
    end
    // schedule alternating own and pinned tasks, then round robin ones, then fetch as worker 0
    for (int k = 0; k < QD + 1; k++) send_word(mk(OP_SCHED, k, k[0], 0, 1, 1, 0));
    for (int k = 0; k < QD + 1; k++) send_word(mk(OP_SCHED, k, 0, 0, 0, 2, 0));
    for (int k = 0; k < 4; k++) send_word(mk(OP_FETCH, 0, 0, 0, 0, 0, 0));
    drain_results();

    // out-of-range worker count and caller mode
    cfg_write(REG_WORKER_COUNT, 0);
    cfg_write(REG_CALLER_MODE, 1);
    send_word(mk(OP_SCHED, 7, 0, 0, 0, 0, 0));
    send_word(mk(OP_FETCH, 0, 0, 0, 0, 1, 0));
    drain_results();
    cfg_write(REG_WORKER_COUNT, 7);
    send_word(mk(OP_SCHED, 8, 1, 3, 1, 3, 0));
    drain_results();

    // random phases over several settings
    items = 0;
    for (int ph = 0; ph < 10; ph++) begin
      cfg_write(REG_CALLER_MODE, $urandom_range(1));
      cfg_write(REG_WORKER_COUNT, (ph == 0) ? 1 : (ph == 1) ? 4 : $urandom_range(7));
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
        default: begin src_idle_pct = 12; snk_stall_pct = 12; end
      endcase
      if (ph == 3) hold_cycles = 600;
      for (int k = 0; k < 95; k++) begin
        send_word(rand_word((ph % 3 == 0) ? 30 : 50));
        items++;
      end
      drain_results();
    end
    cfg_write(REG_CALLER_MODE, 0);
    cfg_write(REG_WORKER_COUNT, 32'(WC_RESET));
    drain_results();

    $display("covered %0d random words, %0d results, %0d steals, %0d full drops",
             items, n_results, n_steals, n_full);
    if (n_errors == 0 && pending_results.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end
endmodule
